/* rtl/core/scs_pkg.sv */
// Shared types, constants and the arctangent table of the checkerboard sky shader.
// No dependencies; imported by scs_cordic, scs_cell, the top level and the testbench.
`default_nettype none
package scs_pkg;

  // Internal CORDIC coordinate width: 32-bit scaled inputs plus gain and sign headroom.
  localparam int CORD_W     = 35;
  // Angle width: signed Q.30 radians, covering +/- 8 radians.
  localparam int ANG_W      = 34;
  // Product of an angle and the unsigned Q8.8 grid scale.
  localparam int PROD_W     = ANG_W + 17;
  // A cell index is the product shifted right by this many bits.
  localparam int CELL_SHIFT = 38;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SCALE  = 2'd0,
    REG_LIGHT_LEVEL = 2'd1,
    REG_DARK_LEVEL  = 2'd2
  } cfg_reg_t;

  // atan(2^-i) in Q.30 radians, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd31: v = 32'd0;
      default: v = 32'd1 << (5'd30 - idx);
    endcase
    return $signed({{(ANG_W-32){1'b0}}, v});
  endfunction

endpackage
`default_nettype wire

/* rtl/core/scs_if.sv */
// Valid/ready channel interfaces of the checkerboard sky shader.
// Depends on nothing; used by the top level and its environment.
`default_nettype none
interface scs_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;

  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface scs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shade;
  logic       is_light;

  modport source (output valid, shade, is_light, input ready);
  modport sink   (input valid, shade, is_light, output ready);
endinterface
`default_nettype wire

/* rtl/core/scs_isqrt.sv */
// Pipelined integer square root of (1 - y*y), one result bit per stage.
// Depends on nothing; carries a sideband word alongside the data.
`default_nettype none
module scs_isqrt #(
  parameter int COORD_WIDTH = 16,
  parameter int SB_W        = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] y,
  input  wire logic [SB_W-1:0]               sb_in,
  output logic                               out_valid,
  output logic [COORD_WIDTH-1:0]             root,
  output logic [SB_W-1:0]                    sb_out
);
  localparam int N_W  = 2 * (COORD_WIDTH - 1) + 1;
  localparam int ST   = COORD_WIDTH + 2;
  localparam logic [N_W-1:0] ONE_SQ = N_W'(1) << (2 * (COORD_WIDTH - 1));

  logic [N_W-1:0]  n_r    [0:COORD_WIDTH];
  logic [N_W-1:0]  root_r [0:COORD_WIDTH];
  logic [N_W-1:0]  ysq_r;
  logic [SB_W-1:0] sb_r   [0:ST-1];
  logic [ST-1:0]   vld_r;

  // Stage 0 squares y at full product width; stage 1 forms the radicand.
  always_ff @(posedge clk) begin
    if (en) begin
      ysq_r     <= N_W'($unsigned((2*COORD_WIDTH)'(y) * (2*COORD_WIDTH)'(y)));
      sb_r[0]   <= sb_in;
      n_r[0]    <= ONE_SQ - ysq_r;
      root_r[0] <= '0;
      sb_r[1]   <= sb_r[0];
    end
  end

  for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_step
    localparam logic [N_W-1:0] BIT = N_W'(1) << (2 * (COORD_WIDTH - 1 - i));
    logic [N_W-1:0] trial;
    assign trial = root_r[i] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_r[i] >= trial) begin
          n_r[i+1]    <= n_r[i] - trial;
          root_r[i+1] <= (root_r[i] >> 1) + BIT;
        end else begin
          n_r[i+1]    <= n_r[i];
          root_r[i+1] <= root_r[i] >> 1;
        end
        sb_r[i+2] <= sb_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[ST-1];
  assign root      = root_r[COORD_WIDTH][COORD_WIDTH-1:0];
  assign sb_out    = sb_r[ST-1];
endmodule
`default_nettype wire

/* rtl/core/scs_cordic.sv */
// Pipelined vectoring CORDIC: atan2(b, a) in signed Q.30 radians.
// Depends on scs_pkg for widths and the arctangent table.
`default_nettype none
module scs_cordic
  import scs_pkg::*;
#(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic signed [COORD_WIDTH:0] a,
  input  wire logic signed [COORD_WIDTH:0] b,
  output logic                             out_valid,
  output logic signed [ANG_W-1:0]          angle
);
  localparam int SCALE = 32 - COORD_WIDTH;

  logic signed [CORD_W-1:0] x_r   [0:CORDIC_STAGES];
  logic signed [CORD_W-1:0] y_r   [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0]  acc_r [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0]   zero_r;
  logic [CORDIC_STAGES:0]   vld_r;

  logic signed [CORD_W-1:0] xa, yb;
  assign xa = CORD_W'(a) <<< SCALE;
  assign yb = CORD_W'(b) <<< SCALE;

  // Entry stage: fold the left half plane onto the right one.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (a == '0) && (b == '0);
      if (xa[CORD_W-1] && !yb[CORD_W-1]) begin
        x_r[0]   <= yb;
        y_r[0]   <= -xa;
        acc_r[0] <= HALF_PI_Q30;
      end else if (xa[CORD_W-1]) begin
        x_r[0]   <= -yb;
        y_r[0]   <= xa;
        acc_r[0] <= -HALF_PI_Q30;
      end else begin
        x_r[0]   <= xa;
        y_r[0]   <= yb;
        acc_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam int S = i % 32;
    logic signed [CORD_W-1:0] xs, ys;
    logic signed [ANG_W-1:0]  ang;
    assign xs  = x_r[i] >>> S;
    assign ys  = y_r[i] >>> S;
    assign ang = atan_entry(5'(S));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][CORD_W-1]) begin
          x_r[i+1]   <= x_r[i] + ys;
          y_r[i+1]   <= y_r[i] - xs;
          acc_r[i+1] <= acc_r[i] + ang;
        end else begin
          x_r[i+1]   <= x_r[i] - ys;
          y_r[i+1]   <= y_r[i] + xs;
          acc_r[i+1] <= acc_r[i] - ang;
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[CORDIC_STAGES-1:0], in_valid};
    end
  end

  assign out_valid = vld_r[CORDIC_STAGES];
  assign angle     = zero_r[CORDIC_STAGES] ? '0 : acc_r[CORDIC_STAGES];
endmodule
`default_nettype wire

/* rtl/core/scs_cell.sv */
// Scales both angles by the grid factor, takes cell parity and picks the shade.
// Depends on scs_pkg; its last register is the block's output register.
`default_nettype none
module scs_cell
  import scs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [ANG_W-1:0] lon,
  input  wire logic signed [ANG_W-1:0] lat,
  input  wire logic [15:0]             grid_scale,
  input  wire logic [7:0]              light_level,
  input  wire logic [7:0]              dark_level,
  output logic                         out_valid,
  output logic [7:0]                   shade,
  output logic                         is_light
);
  logic signed [PROD_W-1:0] plon_r, plat_r;
  logic                     pvld_r, ovld_r;
  logic [7:0]               shade_r;
  logic                     light_r;
  logic signed [16:0]       scale_s;
  logic                     light_nxt;

  assign scale_s = $signed({1'b0, grid_scale});

  // The low bit of floor(p / 2^38) is bit 38 of p; the sum's parity is the XOR.
  assign light_nxt = !(plon_r[CELL_SHIFT] ^ plat_r[CELL_SHIFT]);

  always_ff @(posedge clk) begin
    if (en) begin
      plon_r  <= PROD_W'(lon) * PROD_W'(scale_s);
      plat_r  <= PROD_W'(lat) * PROD_W'(scale_s);
      light_r <= light_nxt;
      shade_r <= light_nxt ? light_level : dark_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else if (en) begin
      pvld_r <= in_valid;
      ovld_r <= pvld_r;
    end
  end

  assign out_valid = ovld_r;
  assign shade     = shade_r;
  assign is_light  = light_r;
endmodule
`default_nettype wire

/* rtl/core/sphere_checker_skybox_shade.sv */
// Checkerboard sky shader: ray direction in, grey level of the sky texel out.
// Throughput is one item per cycle while the output is not stalled; the whole
// pipeline advances on one enable.
// Reset (rst_n, synchronous, active low) empties the pipeline and restores
// grid_scale to 10.0, light_level to 204 and dark_level to 26.
// Depends on scs_pkg, scs_if, scs_isqrt, scs_cordic and scs_cell.
`default_nettype none
module sphere_checker_skybox_shade
  import scs_pkg::*;
#(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  scs_in_if.sink                     in_ch,
  scs_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int SB_W = 3 * COORD_WIDTH;

  // Configuration registers.
  logic [15:0] grid_scale_r;
  logic [7:0]  light_level_r;
  logic [7:0]  dark_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_scale_r  <= 16'd2560;
      light_level_r <= 8'd204;
      dark_level_r  <= 8'd26;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_SCALE:  grid_scale_r  <= cfg_data;
        REG_LIGHT_LEVEL: light_level_r <= cfg_data[7:0];
        REG_DARK_LEVEL:  dark_level_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Every stage moves together. The pipeline stops only when a finished item
  // sits in the output register and the sink does not take it; bubbles travel
  // with the data and are held in place during such a stall.
  logic en;
  assign en          = !(out_ch.valid && !out_ch.ready);
  assign in_ch.ready = en;

  // Square root stage: cos(latitude) = sqrt(1 - y^2). The direction itself
  // rides along as sideband so that both angles start together.
  logic                          sq_valid;
  logic [COORD_WIDTH-1:0]        sq_root;
  logic [SB_W-1:0]               sq_sb;
  logic signed [COORD_WIDTH-1:0] sb_x, sb_y, sb_z;

  scs_isqrt #(
    .COORD_WIDTH (COORD_WIDTH),
    .SB_W        (SB_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .y         (in_ch.dir_y),
    .sb_in     ({in_ch.dir_x, in_ch.dir_y, in_ch.dir_z}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .sb_out    (sq_sb)
  );

  assign sb_x = sq_sb[3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign sb_y = sq_sb[2*COORD_WIDTH-1:COORD_WIDTH];
  assign sb_z = sq_sb[COORD_WIDTH-1:0];

  // Longitude is atan2(z, x); latitude is atan2(y, cos). The root can equal
  // one exactly, so both units take one extra integer bit.
  logic                    lon_valid, lat_valid;
  logic signed [ANG_W-1:0] lon, lat;

  scs_cordic #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic_lon (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .a         ((COORD_WIDTH+1)'(sb_x)),
    .b         ((COORD_WIDTH+1)'(sb_z)),
    .out_valid (lon_valid),
    .angle     (lon)
  );

  scs_cordic #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic_lat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .a         ($signed({1'b0, sq_root})),
    .b         ((COORD_WIDTH+1)'(sb_y)),
    .out_valid (lat_valid),
    .angle     (lat)
  );

  // Cell index parity and shade selection; holds the output register.
  scs_cell u_cell (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (lat_valid),
    .lon         (lon),
    .lat         (lat),
    .grid_scale  (grid_scale_r),
    .light_level (light_level_r),
    .dark_level  (dark_level_r),
    .out_valid   (out_ch.valid),
    .shade       (out_ch.shade),
    .is_light    (out_ch.is_light)
  );

  // The two angle pipelines are identical and must stay in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lon_valid == lat_valid)
    else $error("longitude and latitude pipelines out of step");

  // A waiting result must stall the input side.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while output is blocked");

  // The shade always agrees with the parity flag.
  a_shade: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.is_light ? (out_ch.shade == light_level_r)
                                      : (out_ch.shade == dark_level_r)))
    else $error("shade does not match cell parity");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

/* verif/scs_shade_checker.sv */
// Watches both channels and the register port of the checkerboard sky shader,
// predicts each texel in fixed point and compares. Depends on scs_pkg and scs_if.
`default_nettype none
module scs_shade_checker
  import scs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  scs_in_if                          in_ch,
  scs_out_if                         out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         texels_seen,
  output int                         light_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] shade;
    logic       is_light;
  } texel_t;

  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint ATAN_Q30 [0:15] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};

  logic [15:0] grid_scale;
  logic [7:0]  light_level;
  logic [7:0]  dark_level;
  texel_t      texel_q[$];

  // Floor integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // atan2(b, a) in Q.30 radians by 16 vectoring stages.
  function automatic longint cordic_angle(longint a, longint b);
    longint acc, t, as_, bs_;
    acc = 0;
    if (a == 0 && b == 0) return 0;
    a = a * 65536;
    b = b * 65536;
    if (a < 0) begin
      if (b >= 0) begin
        acc = HALF_PI; t = a; a = b; b = -t;
      end else begin
        acc = -HALF_PI; t = a; a = -b; b = t;
      end
    end
    for (int i = 0; i < 16; i++) begin
      as_ = a >>> i;
      bs_ = b >>> i;
      if (b >= 0) begin
        a = a + bs_; b = b - as_; acc = acc + ATAN_Q30[i];
      end else begin
        a = a - bs_; b = b + as_; acc = acc - ATAN_Q30[i];
      end
    end
    return acc;
  endfunction

  function automatic texel_t shade_texel(logic signed [15:0] dx, logic signed [15:0] dy,
                                         logic signed [15:0] dz);
    longint lon, lat, cu, cv, yv;
    longint unsigned cosv;
    texel_t r;
    yv   = dy;
    cosv = int_sqrt((64'd1 << 30) - longint'(yv * yv));
    lon  = cordic_angle(longint'(dx), longint'(dz));
    lat  = cordic_angle(longint'(cosv), yv);
    cu   = (lon * longint'({48'd0, grid_scale})) >>> CELL_SHIFT;
    cv   = (lat * longint'({48'd0, grid_scale})) >>> CELL_SHIFT;
    r.is_light = ~(cu[0] ^ cv[0]);
    r.shade    = r.is_light ? light_level : dark_level;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  assign pending = texel_q.size();

  initial begin
    fail_count  = 0;
    texels_seen = 0;
    light_seen  = 0;
  end

  always @(posedge clk) begin
    texel_t want;
    if (!rst_n) begin
      grid_scale  <= 16'd2560;
      light_level <= 8'd204;
      dark_level  <= 8'd26;
      texel_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_GRID_SCALE:  grid_scale  <= cfg_data;
          REG_LIGHT_LEVEL: light_level <= cfg_data[7:0];
          REG_DARK_LEVEL:  dark_level  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        texel_q.push_back(shade_texel(in_ch.dir_x, in_ch.dir_y, in_ch.dir_z));
      if (out_ch.valid && out_ch.ready) begin
        if (texel_q.size() == 0) begin
          report_mismatch("unexpected texel", int'(out_ch.shade), -1);
        end else begin
          want = texel_q.pop_front();
          texels_seen++;
          if (want.is_light) light_seen++;
          if (out_ch.shade !== want.shade)
            report_mismatch("shade", int'(out_ch.shade), int'(want.shade));
          if (out_ch.is_light !== want.is_light)
            report_mismatch("is_light", int'(out_ch.is_light), int'(want.is_light));
        end
      end
    end
  end
endmodule
`default_nettype wire

/* verif/tb_sphere_checker_skybox_shade.sv */
// Top of the checkerboard sky shader testbench: clock, reset, ray stimulus,
// register writes and verdict. Depends on scs_pkg, scs_if, scs_shade_checker and sphere_checker_skybox_shade.
`default_nettype none
module tb_sphere_checker_skybox_shade;
  import scs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The pipeline is 37 deep; the drain wait and pre-write pause use a margin.
  localparam int DRAIN_CYCLES = 80;
  // Slowest run: about 1300 items, each facing sender gaps and receiver stalls,
  // plus a long hold-off; this is many times that.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1300;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  scs_in_if #(.COORD_WIDTH(16)) in_ch();
  scs_out_if                    out_ch();

  int fail_count, pending, texels_seen, light_seen;
  int cycles;
  int idle_pct;      // chance in a hundred that the sender skips a cycle
  int stall_pct;     // chance in a hundred that the receiver stalls a cycle
  logic hold_off;    // long receiver hold-off to fill the pipeline
  logic in_taken;    // input item accepted at the last rising edge

  sphere_checker_skybox_shade u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  scs_shade_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .texels_seen(texels_seen), .light_seen(light_seen)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Acceptance is latched at the rising edge so the sender reads a settled value.
  always @(posedge clk) in_taken <= in_ch.valid && in_ch.ready;

  // The receiver changes ready only at the falling edge.
  always @(negedge clk)
    out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);

  // A run that never drains is a failure in its own right.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d texels outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one ray direction; called and returning at a falling edge. The valid
  // line is only lowered for a gap, so it is never dropped and raised in one step.
  task automatic send_ray(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dir_x <= dx;
    in_ch.dir_y <= dy;
    in_ch.dir_z <= dz;
    do @(negedge clk); while (!in_taken);
  endtask

  // Registers change only with the pipeline empty: wait for every texel, then
  // let the pipeline run dry.
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_levels(logic [15:0] scale, logic [7:0] lt, logic [7:0] dk);
    write_reg(REG_GRID_SCALE, scale);
    write_reg(REG_LIGHT_LEVEL, {8'd0, lt});
    write_reg(REG_DARK_LEVEL, {8'd0, dk});
  endtask

  // Rays carry fully random bits; about one in four has one field pushed near an axis or a pole.
  task automatic send_random_rays(int count);
    logic [15:0] rx, ry, rz;
    for (int i = 0; i < count; i++) begin
      rx = 16'($urandom);
      ry = 16'($urandom);
      rz = 16'($urandom);
      if ($urandom_range(3) == 0) begin
        // Rays near the axes and poles stress the quadrant folding.
        case ($urandom_range(2))
          0: rz = 16'($urandom_range(3) - 2);
          1: ry = $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(15))
                                    : 16'h8000 + 16'($urandom_range(15));
          default: rx = 16'($urandom_range(3) - 2);
        endcase
      end
      send_ray(rx, ry, rz);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.dir_x  = '0;
    in_ch.dir_y  = '0;
    in_ch.dir_z  = '0;
    out_ch.ready = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_off     = 1'b0;
    cycles       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rays at reset settings: the zero vector, negative x on the
    // seam where longitude is +pi, both poles, and every field at its extremes.
    send_ray(16'h0000, 16'h0000, 16'h0000);
    send_ray(16'h8000, 16'h0000, 16'h0000);
    send_ray(16'hC000, 16'h1000, 16'h0000);
    send_ray(16'h7FFF, 16'h0000, 16'h0000);
    send_ray(16'h0000, 16'h7FFF, 16'h0000);
    send_ray(16'h0000, 16'h8000, 16'h0000);
    send_ray(16'h0000, 16'h0000, 16'h7FFF);
    send_ray(16'h0000, 16'h0000, 16'h8000);
    send_ray(16'h8000, 16'h8000, 16'h8000);
    send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_ray(16'h8000, 16'h0000, 16'hFFFF);
    send_ray(16'h8000, 16'h0000, 16'h0001);
    send_ray(16'h5A82, 16'h0000, 16'hA57E);
    send_ray(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_ray(16'h0001, 16'h0001, 16'h0001);

    // Grid scale of zero puts every ray in cell zero, so all come out light.
    set_levels(16'h0000, 8'hFF, 8'h00);
    send_ray(16'h8000, 16'h8000, 16'h8000);
    send_ray(16'h1234, 16'hEDCB, 16'h7FFF);
    send_ray(16'h8000, 16'h0000, 16'h0000);

    // Largest grid scale, with the level registers swapped to the other extremes.
    set_levels(16'hFFFF, 8'h00, 8'hFF);
    send_ray(16'h7FFF, 16'h4000, 16'h8000);
    send_ray(16'h8000, 16'h8000, 16'h0000);
    send_ray(16'h0000, 16'h7FFF, 16'h0000);

    // Random phases, each under its own setting and idling pattern.
    set_levels(16'd2560, 8'd204, 8'd26);
    send_random_rays(RANDOM_ITEMS / 5);

    set_levels(16'd1, 8'($urandom_range(255)), 8'($urandom_range(255)));
    idle_pct = 73;
    send_random_rays(RANDOM_ITEMS / 5);

    set_levels(16'hFFFF, 8'd255, 8'd0);
    idle_pct  = 0;
    stall_pct = 73;
    send_random_rays(RANDOM_ITEMS / 5);

    set_levels(16'($urandom_range(65535)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
    idle_pct  = 21;
    stall_pct = 21;
    send_random_rays(RANDOM_ITEMS / 5);

    // The receiver holds off for a long stretch while rays keep coming, so the
    // pipeline fills and the block must push back on its input.
    set_levels(16'($urandom_range(8192)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random_rays(RANDOM_ITEMS / 5);
    join

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d sky texels (%0d light) over eight register settings,",
             texels_seen, light_seen);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
